// File: hdl/pic_pkg.sv
// Shared types, constants and the Q.16 saturation helper for the PI controller.
`default_nettype none

package pic_pkg;

	localparam int ERR_W   = 17;  // setpoint - measured
	localparam int GAIN_W  = 16;  // kp, ki, sample period
	localparam int MC_W    = 33;  // multiplicand: error or error*ki
	localparam int ACC_W   = 49;  // full product error*ki*period
	localparam int INTEG_W = 25;  // integrator, Q9.16
	localparam int SUM_W   = 42;  // sums ahead of the clamp
	localparam int DRIVE_W = 9;
	localparam int DIG_W   = 4;   // multiplier digit per cycle
	localparam int STEPS   = GAIN_W / DIG_W;
	localparam int CNT_W   = $clog2(STEPS);
	localparam int CFG_W   = 2;

	localparam logic [CFG_W-1:0] REG_KP     = 2'd0;
	localparam logic [CFG_W-1:0] REG_KI     = 2'd1;
	localparam logic [CFG_W-1:0] REG_PERIOD = 2'd2;

	localparam logic signed [GAIN_W-1:0] KP_RESET     = 16'sd256;
	localparam logic signed [GAIN_W-1:0] KI_RESET     = 16'sd0;
	localparam logic        [GAIN_W-1:0] PERIOD_RESET = 16'd655;

	// +/-255.0 in Q.16
	localparam logic signed [SUM_W-1:0] LIMIT_HI = 42'sd16711680;
	localparam logic signed [SUM_W-1:0] LIMIT_LO = -42'sd16711680;

	typedef struct packed {
		logic start;
		logic msigned;  // top digit of the multiplier carries the sign
	} mul_cmd_t;

	typedef struct packed {
		logic start;
		logic take;
	} post_ctl_t;

	function automatic logic signed [INTEG_W-1:0] sat_q16(input logic signed [SUM_W-1:0] v);
		logic signed [SUM_W-1:0] r;
		begin
			if (v > LIMIT_HI) r = LIMIT_HI;
			else if (v < LIMIT_LO) r = LIMIT_LO;
			else r = v;
			sat_q16 = r[INTEG_W-1:0];
		end
	endfunction

endpackage

`default_nettype wire

// File: hdl/pic_dmul.sv
// Digit-serial multiplier: one 4-bit multiplier digit per cycle into a 49-bit accumulator.
`default_nettype none

module pic_dmul
	import pic_pkg::*;
(
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire mul_cmd_t                cmd,
	input  wire logic signed [MC_W-1:0]  mcand,
	input  wire logic [GAIN_W-1:0]       mplier,
	output logic signed [ACC_W-1:0]      product,
	output logic                         done
);

	logic                      busy_q;
	logic                      done_q;
	logic [CNT_W-1:0]          cnt_q;
	logic                      msigned_q;
	logic signed [ACC_W-1:0]   mcand_q;
	logic [GAIN_W-1:0]         mplier_q;
	logic signed [ACC_W-1:0]   acc_q;
	logic                      last;
	logic signed [DIG_W:0]     sdig;
	logic signed [ACC_W+DIG_W:0] pp;

	assign last = (cnt_q == CNT_W'(STEPS - 1));
	// top digit of a signed multiplier weighs negative
	assign sdig = (msigned_q && last) ? {mplier_q[DIG_W-1], mplier_q[DIG_W-1:0]}
	                                  : {1'b0, mplier_q[DIG_W-1:0]};
	assign pp   = mcand_q * sdig;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q    <= 1'b0;
			done_q    <= 1'b0;
			cnt_q     <= '0;
			msigned_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (cmd.start) begin
				busy_q    <= 1'b1;
				cnt_q     <= '0;
				msigned_q <= cmd.msigned;
			end else if (busy_q) begin
				cnt_q <= cnt_q + CNT_W'(1);
				if (last) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			acc_q    <= '0;
			mcand_q  <= {{(ACC_W-MC_W){mcand[MC_W-1]}}, mcand};
			mplier_q <= mplier;
		end else if (busy_q) begin
			acc_q    <= acc_q + pp[ACC_W-1:0];
			mcand_q  <= mcand_q <<< DIG_W;
			mplier_q <= mplier_q >> DIG_W;
		end
	end

	assign product = acc_q;
	assign done    = done_q;

	assert property (@(posedge clk) disable iff (!arst_n) cmd.start |-> !busy_q)
		else $error("multiplier restarted while busy");

endmodule

`default_nettype wire

// File: hdl/pic_post.sv
// Integrator update with clamp, then drive = clamp(P + I) truncated toward zero.
`default_nettype none

module pic_post
	import pic_pkg::*;
(
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire post_ctl_t               ctl,
	input  wire logic signed [ACC_W-1:0] prod_p,
	input  wire logic signed [ACC_W-1:0] prod_i,
	output logic                         valid,
	output logic signed [DRIVE_W-1:0]    drive
);

	localparam int P_W = MC_W + 8;  // P in Q.16

	logic signed [INTEG_W-1:0] integ_q;
	logic                      valid_s1;
	logic signed [MC_W-1:0]    p_s1;
	logic signed [SUM_W-1:0]   integ_sum;
	logic signed [SUM_W-1:0]   out_sum;
	logic signed [INTEG_W-1:0] m_sat;
	logic signed [INTEG_W-1:0] m_adj;
	logic signed [P_W-1:0]     p_q16;

	// increment floor(inc / 256) is the arithmetic shift, i.e. the upper bits
	assign integ_sum = SUM_W'(integ_q) + SUM_W'($signed(prod_i[ACC_W-1:8]));

	assign p_q16   = {p_s1, 8'd0};
	assign out_sum = SUM_W'(p_q16) + SUM_W'(integ_q);
	assign m_sat   = sat_q16(out_sum);
	// bias negatives so the shift truncates toward zero
	assign m_adj   = m_sat + (m_sat[INTEG_W-1] ? INTEG_W'(65535) : INTEG_W'(0));
	assign drive   = m_adj[INTEG_W-1:16];
	assign valid   = valid_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			integ_q  <= '0;
			valid_s1 <= 1'b0;
		end else begin
			if (ctl.start) begin
				integ_q  <= sat_q16(integ_sum);
				valid_s1 <= 1'b1;
			end else if (ctl.take) begin
				valid_s1 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.start) p_s1 <= prod_p[MC_W-1:0];
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		(integ_q <= $signed(LIMIT_HI[INTEG_W-1:0])) &&
		(integ_q >= $signed(LIMIT_LO[INTEG_W-1:0])))
		else $error("integrator out of +/-255");

endmodule

`default_nettype wire

// File: hdl/pi_controller_clamped.sv
// PI controller top: config registers, sequencer, two digit-serial multipliers, output register.
// Order: 4 digit steps for e*kp and e*ki, a restart of the integral multiplier, 4 for e*ki*period,
//   integrator update, output register load.
// A new item is accepted only once the last result has moved to the output register; the pace is
//   set by the two passes through the 4-bit digit multiplier that form the integral increment.
// Reset (arst_n low, asynchronous): integrator zero, kp = 1.0, ki = 0, period = 655,
//   no item in flight and no result pending.
`default_nettype none

module pi_controller_clamped
	import pic_pkg::*;
(
	input  wire logic               clk,
	input  wire logic               arst_n,
	// config write port
	input  wire logic               cfg_wr_en,
	input  wire logic [CFG_W-1:0]   cfg_index,
	input  wire logic [GAIN_W-1:0]  cfg_data,
	// input items
	input  wire logic               s_tvalid,
	output logic                    s_tready,
	input  wire logic [31:0]        s_tdata,   // [15:0] setpoint, [31:16] measured
	// result items
	output logic                    m_tvalid,
	input  wire logic               m_tready,
	output logic [15:0]             m_tdata    // [8:0] drive, [15:9] zero
);

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_MUL_A = 2'd1;  // e*kp and e*ki
	localparam logic [1:0] ST_MUL_B = 2'd2;  // (e*ki)*period
	localparam logic [1:0] ST_POST  = 2'd3;  // integrator update, wait for output slot

	logic [1:0]                state_q;
	logic signed [GAIN_W-1:0]  kp_q;
	logic signed [GAIN_W-1:0]  ki_q;
	logic [GAIN_W-1:0]         period_q;
	logic                      m_tvalid_q;
	logic signed [DRIVE_W-1:0] drive_q;

	logic                      accept;
	logic signed [ERR_W-1:0]   err;
	logic signed [MC_W-1:0]    err_ext;
	mul_cmd_t                  cmd_p;
	mul_cmd_t                  cmd_i;
	logic signed [MC_W-1:0]    mcand_i;
	logic [GAIN_W-1:0]         mplier_i;
	logic signed [ACC_W-1:0]   prod_p;
	logic signed [ACC_W-1:0]   prod_i;
	logic                      done_p;
	logic                      done_i;
	post_ctl_t                 post_ctl;
	logic                      post_valid;
	logic signed [DRIVE_W-1:0] post_drive;

	assign s_tready = (state_q == ST_IDLE);
	assign accept   = s_tvalid && s_tready;

	// error is exact in 17 bits
	assign err     = ERR_W'($signed(s_tdata[15:0])) - ERR_W'($signed(s_tdata[31:16]));
	assign err_ext = MC_W'(err);

	// proportional multiplier: e * kp, signed digits
	assign cmd_p.start   = accept;
	assign cmd_p.msigned = 1'b1;

	// integral multiplier: first e * ki (signed), then (e*ki) * period (unsigned)
	assign cmd_i.start   = accept || ((state_q == ST_MUL_A) && done_i);
	assign cmd_i.msigned = (state_q == ST_IDLE);
	assign mcand_i       = (state_q == ST_IDLE) ? err_ext : prod_i[MC_W-1:0];
	assign mplier_i      = (state_q == ST_IDLE) ? ki_q : period_q;

	pic_dmul u_mul_p (
		.clk     (clk),
		.arst_n  (arst_n),
		.cmd     (cmd_p),
		.mcand   (err_ext),
		.mplier  (kp_q),
		.product (prod_p),
		.done    (done_p)
	);

	pic_dmul u_mul_i (
		.clk     (clk),
		.arst_n  (arst_n),
		.cmd     (cmd_i),
		.mcand   (mcand_i),
		.mplier  (mplier_i),
		.product (prod_i),
		.done    (done_i)
	);

	// result moves to the output register once the slot is free or being emptied
	assign post_ctl.start = (state_q == ST_MUL_B) && done_i;
	assign post_ctl.take  = post_valid && (!m_tvalid_q || m_tready);

	pic_post u_post (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (post_ctl),
		.prod_p (prod_p),
		.prod_i (prod_i),
		.valid  (post_valid),
		.drive  (post_drive)
	);

	// config registers; writes must arrive only while idle, which the block itself does not enforce
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kp_q     <= KP_RESET;
			ki_q     <= KI_RESET;
			period_q <= PERIOD_RESET;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				REG_KP:     kp_q     <= cfg_data;
				REG_KI:     ki_q     <= cfg_data;
				REG_PERIOD: period_q <= cfg_data;
				default:    ;
			endcase
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			unique case (state_q)
				ST_IDLE:  if (accept) state_q <= ST_MUL_A;
				ST_MUL_A: if (done_i) state_q <= ST_MUL_B;
				ST_MUL_B: if (done_i) state_q <= ST_POST;
				ST_POST:  if (post_ctl.take) state_q <= ST_IDLE;
				default:  state_q <= ST_IDLE;
			endcase
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (post_ctl.take) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (post_ctl.take) drive_q <= post_drive;
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {{(16-DRIVE_W){1'b0}}, drive_q};

	// both multipliers finish together in the first pass
	assert property (@(posedge clk) disable iff (!arst_n)
		done_p |-> (done_i && (state_q == ST_MUL_A)))
		else $error("proportional product out of step");

	assert property (@(posedge clk) disable iff (!arst_n)
		done_i |-> ((state_q == ST_MUL_A) || (state_q == ST_MUL_B)))
		else $error("integral multiplier done outside its passes");

	assert property (@(posedge clk) disable iff (!arst_n)
		post_valid |-> (state_q == ST_POST))
		else $error("post result outside post state");

	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[8:0] != 9'h100))
		else $error("drive beyond -255");

endmodule

`default_nettype wire

// File: test/pi_controller_clamped_tb.sv
// Self-checking testbench for the clamped PI controller: directed corner items, then random phases.
`default_nettype none

module pi_controller_clamped_tb;
	import pic_pkg::*;

	// Longest run of cycles with no item moving on either side before the run is abandoned.
	// A correct run never comes near it, since items keep moving and idle gaps are short.
	localparam int STALL_LIMIT = 2000;
	// +/-255.0 in Q.16, held at full width for the predictor
	localparam longint Q16_LIMIT = 64'sd16711680;

	logic                  clk       = 1'b0;
	logic                  arst_n    = 1'b0;
	logic                  cfg_wr_en = 1'b0;
	logic [CFG_W-1:0]      cfg_index = '0;
	logic [GAIN_W-1:0]     cfg_data  = '0;
	logic                  s_tvalid  = 1'b0;
	wire logic             s_tready;
	logic [31:0]           s_tdata   = '0;   // [15:0] setpoint, [31:16] measured
	wire logic             m_tvalid;
	logic                  m_tready  = 1'b0;
	wire logic [15:0]      m_tdata;          // [8:0] drive, [15:9] zero

	pi_controller_clamped i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// ---------------------------------------------------------------------------------
	// Controller state as the testbench sees it: gains, period and the Q9.16 integrator.
	// Values after reset; only set_reg changes the gains, only predict_drive the integrator.
	// ---------------------------------------------------------------------------------
	logic signed [GAIN_W-1:0]  kp_q8      = KP_RESET;
	logic signed [GAIN_W-1:0]  ki_q8      = KI_RESET;
	logic        [GAIN_W-1:0]  period_q16 = PERIOD_RESET;
	logic signed [INTEG_W-1:0] integ_q16  = '0;

	typedef struct {
		logic signed [DRIVE_W-1:0] drive;
		int                        seq;
	} drive_exp_t;

	drive_exp_t drive_q[$];      // drives still owed by the block, oldest first
	int         items_sent   = 0;
	int         errors       = 0;
	int         stall_cycles = 0;
	int         snd_idle_pct = 0;  // chance per cycle that the sender holds off
	int         rcv_idle_pct = 0;  // chance per cycle that the receiver stalls

	function automatic longint clamp_q16(input longint v);
		if (v > Q16_LIMIT) return Q16_LIMIT;
		if (v < -Q16_LIMIT) return -Q16_LIMIT;
		return v;
	endfunction

	// One control update. Everything is held in 64 bits, so nothing wraps and only the
	// two clamps limit values. The increment is floored (arithmetic shift), the final
	// Q.16 to integer step truncates toward zero (signed division).
	function automatic logic signed [DRIVE_W-1:0] predict_drive(input logic signed [15:0] sp,
			input logic signed [15:0] ms);
		longint err;
		longint prop;
		longint incr;
		longint acc;
		longint mix;
		longint drv;
		err  = longint'(sp) - longint'(ms);
		prop = err * longint'(kp_q8) * 256;
		incr = err * longint'(ki_q8) * longint'({48'd0, period_q16});
		acc  = clamp_q16(longint'(integ_q16) + (incr >>> 8));
		integ_q16 = acc[INTEG_W-1:0];
		mix  = clamp_q16(prop + acc);
		drv  = mix / 65536;
		return drv[DRIVE_W-1:0];
	endfunction

	task automatic report_mismatch(input string msg);
		$display("ERROR at %0t: %s", $realtime, msg);
		errors++;
	endtask

	// ---------------------------------------------------------------------------------
	// Result side: ready is redrawn every falling edge, results are taken at the rising
	// edge and matched against the oldest owed drive.
	// ---------------------------------------------------------------------------------
	always @(negedge clk) begin
		m_tready <= ($urandom_range(0, 99) >= rcv_idle_pct);
	end

	always @(posedge clk) begin
		drive_exp_t e;
		if (arst_n && m_tvalid && m_tready) begin
			if (drive_q.size() == 0) begin
				report_mismatch($sformatf("result 0x%04h with no item waiting", m_tdata));
			end else begin
				e = drive_q.pop_front();
				if (m_tdata[DRIVE_W-1:0] !== e.drive)
					report_mismatch($sformatf("item %0d: drive %0d, want %0d", e.seq,
						$signed(m_tdata[DRIVE_W-1:0]), e.drive));
				if (m_tdata[15:DRIVE_W] !== '0)
					report_mismatch($sformatf("item %0d: padding bits 0x%02h not zero", e.seq,
						m_tdata[15:DRIVE_W]));
			end
		end
	end

	// Watchdog: any item moving on either side resets the count.
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
			stall_cycles = 0;
		else
			stall_cycles++;
		if (stall_cycles >= STALL_LIMIT) begin
			$display("timeout: no item moved for %0d cycles", STALL_LIMIT);
			$display("CHECKS FAILED");
			$finish;
		end
	end

	// ---------------------------------------------------------------------------------
	// Input side. All tasks are entered just after a falling edge and leave just after
	// one, so each signal gets at most one assignment per time step. send_item leaves
	// tvalid high; the next call either lowers it (hold-off) or loads the next item.
	// ---------------------------------------------------------------------------------
	task automatic send_item(input logic [15:0] sp, input logic [15:0] ms);
		drive_exp_t e;
		while ($urandom_range(0, 99) < snd_idle_pct) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {ms, sp};
		do @(posedge clk); while (!s_tready);
		e.drive = predict_drive(sp, ms);
		e.seq   = items_sent;
		drive_q.push_back(e);
		items_sent++;
		@(negedge clk);
	endtask

	// Drop tvalid so the last item is not offered twice.
	task automatic sender_rest();
		s_tvalid <= 1'b0;
		@(negedge clk);
	endtask

	task automatic wait_drained();
		while (drive_q.size() != 0) @(negedge clk);
	endtask

	// Register write, only called with nothing in flight.
	task automatic set_reg(input logic [CFG_W-1:0] idx, input logic [GAIN_W-1:0] val);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		case (idx)
			REG_KP:     kp_q8      = val;
			REG_KI:     ki_q8      = val;
			REG_PERIOD: period_q16 = val;
			default:    ;
		endcase
		@(negedge clk);
		cfg_wr_en <= 1'b0;
		@(negedge clk);
	endtask

	task automatic set_gains(input logic [15:0] kp, input logic [15:0] ki,
			input logic [15:0] period);
		sender_rest();
		wait_drained();
		set_reg(REG_KP, kp);
		set_reg(REG_KI, ki);
		set_reg(REG_PERIOD, period);
	endtask

	// ---------------------------------------------------------------------------------
	// Directed tests
	// ---------------------------------------------------------------------------------

	// Gains as left by reset: kp = 1.0, ki = 0, so the integrator must hold at zero.
	task automatic test_reset_values();
		send_item(16'sd0, 16'sd0);
		send_item(16'sd100, -16'sd100);           // +200, inside the clamp
		send_item(16'sd5, 16'sd7);                // small negative error
		send_item(16'h7FFF, 16'h8000);            // largest positive error, saturates
		send_item(16'h8000, 16'h7FFF);            // largest negative error, saturates
		send_item(16'h8000, 16'h8000);
		send_item(16'h7FFF, 16'h7FFF);
	endtask

	// Integral only, huge gain: integrator slams into each rail, then backs off.
	task automatic test_integrator_clamp();
		set_gains(16'h0000, 16'h7FFF, 16'hFFFF);
		send_item(16'h7FFF, 16'h8000);            // up to +255
		send_item(16'sd0, 16'sd0);                // zero error: stays on the rail
		send_item(16'h8000, 16'h7FFF);            // down to -255
		send_item(16'sd1, 16'sd0);                // unit error pulls it off the rail
		set_gains(16'h0000, 16'h8000, 16'hFFFF);  // most negative ki
		send_item(16'sd1, 16'sd0);
		send_item(-16'sd1, 16'sd0);               // negative error times negative ki: positive increment
	endtask

	// Zero period freezes the integrator whatever ki is; then the smallest period.
	task automatic test_hold_integrator();
		set_gains(16'sd256, 16'h7FFF, 16'h0000);
		send_item(16'sd1000, 16'sd0);
		send_item(-16'sd1000, 16'sd0);
		set_gains(16'sd256, 16'h7FFF, 16'h0001);
		send_item(16'sd300, 16'sd0);
		send_item(-16'sd3, 16'sd0);
	endtask

	// Extreme proportional gains, with the integrator also moving.
	task automatic test_extreme_gains();
		set_gains(16'h8000, 16'h7FFF, PERIOD_RESET);
		send_item(16'sd1, 16'sd0);
		send_item(16'sd0, 16'sd1);
		send_item(16'h7FFF, 16'h8000);
		set_gains(16'h7FFF, 16'h8000, PERIOD_RESET);
		send_item(16'sd1, 16'sd0);
		send_item(-16'sd2, 16'sd0);
		send_item(16'h8000, 16'h7FFF);
	endtask

	// ---------------------------------------------------------------------------------
	// Random phases
	// ---------------------------------------------------------------------------------
	function automatic logic [15:0] pick_gain();
		int sel;
		sel = $urandom_range(0, 7);
		case (sel)
			0:       return 16'h8000;
			1:       return 16'h7FFF;
			2:       return 16'h0000;
			3:       return 16'sd256;
			4, 5:    return 16'($signed($urandom_range(0, 2048)) - 1024);
			default: return 16'($urandom);
		endcase
	endfunction

	// Each phase is split into segments. Between segments the sender waits until every
	// owed drive is back, then the gains are redrawn. The first two segments use the
	// register extremes; the integrator carries over from segment to segment.
	task automatic run_random_phase(input int snd_pct, input int rcv_pct, input int n_items);
		int         seg;
		int         k;
		int         sel;
		int         delta;
		logic [15:0] sp;
		logic [15:0] ms;
		logic [15:0] per;
		snd_idle_pct = snd_pct;
		rcv_idle_pct = rcv_pct;
		for (seg = 0; seg < 6; seg++) begin
			if (seg == 0) begin
				set_gains(16'h8000, 16'h7FFF, 16'hFFFF);
			end else if (seg == 1) begin
				set_gains(16'h7FFF, 16'h8000, 16'h0000);
			end else begin
				sel = $urandom_range(0, 5);
				case (sel)
					0:       per = 16'h0000;
					1:       per = 16'hFFFF;
					2:       per = PERIOD_RESET;
					default: per = 16'($urandom);
				endcase
				set_gains(pick_gain(), pick_gain(), per);
			end
			for (k = 0; k < n_items / 6; k++) begin
				sel = $urandom_range(0, 99);
				sp  = 16'($urandom);
				if (sel < 55) begin
					// loop near its setpoint: small error
					delta = $signed($urandom_range(0, 800)) - 400;
					ms    = 16'($signed(sp) - delta);
				end else if (sel < 80) begin
					ms = 16'($urandom);
				end else if (sel < 90) begin
					case ($urandom_range(0, 4))
						0:       sp = 16'h8000;
						1:       sp = 16'h7FFF;
						2:       sp = 16'h0000;
						3:       sp = 16'hFFFF;
						default: sp = 16'h0001;
					endcase
					case ($urandom_range(0, 4))
						0:       ms = 16'h8000;
						1:       ms = 16'h7FFF;
						2:       ms = 16'h0000;
						3:       ms = 16'hFFFF;
						default: ms = 16'h0001;
					endcase
				end else begin
					ms = sp;  // zero error
				end
				send_item(sp, ms);
			end
		end
	endtask

	initial begin
		// reset held from time zero, released on a falling edge
		repeat (12) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		snd_idle_pct = 34;
		rcv_idle_pct = 46;
		test_reset_values();
		test_integrator_clamp();
		test_hold_integrator();
		test_extreme_gains();

		run_random_phase(34, 46, 366);
		run_random_phase(46, 34, 366);
		run_random_phase(0, 0, 366);

		sender_rest();
		wait_drained();
		repeat (24) @(negedge clk);  // room for any stray result after the last one
		if (errors == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule

`default_nettype wire
